// File: rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int unsigned MemUnitsDef  = 128;
  localparam int unsigned MaxBlocksDef = 128;

  localparam logic [1:0] ModeAlloc  = 2'd0;
  localparam logic [1:0] ModeErase  = 2'd1;
  localparam logic [1:0] ModeDefrag = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoRoom  = 2'd1;
  localparam logic [1:0] StIllegal = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic [7:0] UnitsReset = 8'd128;

endpackage

// File: rtl/ffa_core.sv
module ffa_core #(
  parameter int unsigned MemUnits  = ffa_pkg::MemUnitsDef,
  parameter int unsigned MaxBlocks = ffa_pkg::MaxBlocksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] alloc_size_i,
  input  logic [7:0] erase_handle_i,
  input  logic [7:0] units_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [7:0] new_handle_o,
  output logic       idle_o
);

  localparam int unsigned UW = (MemUnits > 1) ? $clog2(MemUnits) : 1;
  localparam int unsigned BW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned UC = $clog2(MemUnits + 1);
  localparam int unsigned BC = $clog2(MaxBlocks + 1);
  // address counters hold one past the last unit, and one past that for run ends
  localparam int unsigned AW = UC + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_MARK, S_E_RD, S_E_CLR, S_E_FREE,
    S_D_SCAN, S_D_RD, S_D_EVAL, S_D_PUT, S_D_FILL, S_DONE, S_CLR
  } state_e;

  typedef struct packed {
    logic          live;
    logic [UC-1:0] start;
    logic [UC-1:0] size;
  } blk_t;

  // unit busy map and block table, both synchronous memories with registered reads
  logic umap_mem [MemUnits];
  blk_t btab_mem [MaxBlocks];

  state_e        state_q;
  logic [BC-1:0] issued_q;
  logic [AW-1:0] lim_q, size_q, a_q, run_q, k_q, next_q, best_start_q, prev_q;
  logic [BC-1:0] i_q, best_q;
  logic          found_q, have_prev_q;
  logic [1:0]    status_q;
  logic [7:0]    hdl_q;
  logic          done_q;
  blk_t          brd_q;
  logic          urd_q;

  logic          u_we, u_wd, b_we;
  logic [UW-1:0] u_wa, u_ra;
  logic [BW-1:0] b_wa, b_ra;
  blk_t          b_wd;

  always_ff @(posedge clk_i) begin
    if (u_we) umap_mem[u_wa] <= u_wd;
    urd_q <= umap_mem[u_ra];
    if (b_we) btab_mem[b_wa] <= b_wd;
    brd_q <= btab_mem[b_ra];
  end

  // memory ports from the sequencer state
  always_comb begin
    u_we = 1'b0; u_wd = 1'b0;
    u_wa = k_q[UW-1:0];
    u_ra = run_q[UW-1:0];
    b_we = 1'b0; b_wa = i_q[BW-1:0]; b_wd = brd_q;
    b_ra = i_q[BW-1:0];
    case (state_q)
      S_A_MARK: begin
        u_we = 1'b1; u_wd = 1'b1;
        b_we = (k_q == a_q);
        b_wa = issued_q[BW-1:0];
        b_wd = '{live: 1'b1, start: a_q[UC-1:0], size: size_q[UC-1:0]};
      end
      S_E_FREE: begin
        u_we = 1'b1;
        u_wd = 1'b0;
        b_we = (k_q == AW'(brd_q.start));
        b_wa = i_q[BW-1:0];
        b_wd = '{live: 1'b0, start: brd_q.start, size: brd_q.size};
      end
      S_D_PUT: begin
        b_we = (k_q != '0); b_wa = best_q[BW-1:0];
        b_wd = '{live: 1'b1, start: next_q[UC-1:0], size: brd_q.size};
        b_ra = best_q[BW-1:0];
      end
      S_D_FILL: begin
        u_we = 1'b1; u_wd = (k_q < next_q);
      end
      S_CLR: begin
        u_we = 1'b1; u_wd = 1'b0;
      end
      default: ;
    endcase
  end

  // command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      issued_q <= '0;
      done_q   <= 1'b0;
      status_q <= ffa_pkg::StOk;
      hdl_q    <= '0;
      k_q <= '0; a_q <= '0; run_q <= '0; size_q <= '0; lim_q <= '0;
      next_q <= '0; i_q <= '0; best_q <= '0; best_start_q <= '0; found_q <= 1'b0;
      prev_q <= '0; have_prev_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_DONE);
      case (state_q)
        S_IDLE: begin
          if (go_i) begin
            hdl_q    <= '0;
            lim_q    <= (AW'(units_i) > AW'(MemUnits)) ? AW'(MemUnits) : AW'(units_i);
            size_q   <= AW'(alloc_size_i);
            a_q <= '0; run_q <= '0; k_q <= '0;
            case (mode_i)
              ffa_pkg::ModeAlloc: begin
                if (issued_q >= BC'(MaxBlocks)) begin
                  status_q <= ffa_pkg::StFull; state_q <= S_DONE;
                end else if (alloc_size_i == 8'd0 ||
                             AW'(alloc_size_i) >
                             ((AW'(units_i) > AW'(MemUnits)) ? AW'(MemUnits)
                                                             : AW'(units_i))) begin
                  status_q <= ffa_pkg::StNoRoom; state_q <= S_DONE;
                end else begin
                  status_q <= ffa_pkg::StOk;
                  state_q <= S_A_RD;
                end
              end
              ffa_pkg::ModeErase: begin
                if (erase_handle_i == 8'd0 || 9'(erase_handle_i) > 9'(issued_q)) begin
                  status_q <= ffa_pkg::StIllegal; state_q <= S_DONE;
                end else begin
                  status_q <= ffa_pkg::StOk;
                  i_q <= BC'(erase_handle_i - 8'd1);
                  state_q <= S_E_RD;
                end
              end
              ffa_pkg::ModeDefrag: begin
                status_q <= ffa_pkg::StOk;
                next_q <= '0; i_q <= '0; found_q <= 1'b0; have_prev_q <= 1'b0;
                state_q <= S_D_SCAN;
              end
              default: begin
                status_q <= ffa_pkg::StOk;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        // alloc: run_q walks units from candidate a_q; restart past a busy unit
        S_A_RD: begin
          if (a_q + size_q > lim_q) begin
            status_q <= ffa_pkg::StNoRoom; state_q <= S_DONE;
          end else if (run_q == a_q + size_q) begin
            k_q <= a_q; state_q <= S_A_MARK;
          end else begin
            state_q <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (urd_q) begin
            a_q <= run_q + 1'b1; run_q <= run_q + 1'b1;
          end else begin
            run_q <= run_q + 1'b1;
          end
          state_q <= S_A_RD;
        end
        S_A_MARK: begin
          k_q <= k_q + 1'b1;
          if (k_q + 1'b1 == a_q + size_q) begin
            issued_q <= issued_q + 1'b1;
            hdl_q    <= 8'(issued_q + 1'b1);
            state_q  <= S_DONE;
          end
        end
        S_E_RD: state_q <= S_E_CLR;
        // erase: reject a dead entry, else free its units from the start
        S_E_CLR: begin
          if (!brd_q.live) begin
            status_q <= ffa_pkg::StIllegal; state_q <= S_DONE;
          end else begin
            k_q <= AW'(brd_q.start);
            state_q <= S_E_FREE;
          end
        end
        S_E_FREE: begin
          k_q <= k_q + 1'b1;
          if (k_q + 1'b1 >= AW'(brd_q.start) + AW'(brd_q.size)) state_q <= S_DONE;
        end
        // defrag: each pass finds the lowest live block above the last one placed
        S_D_SCAN: begin
          if (i_q == issued_q) begin
            if (found_q) begin
              state_q <= S_D_PUT;
            end else begin
              k_q <= '0; state_q <= S_D_FILL;
            end
          end else begin
            state_q <= S_D_RD;
          end
        end
        S_D_RD: state_q <= S_D_EVAL;
        S_D_EVAL: begin
          if (brd_q.live && (!have_prev_q || AW'(brd_q.start) > prev_q) &&
              (!found_q || AW'(brd_q.start) < best_start_q)) begin
            found_q <= 1'b1; best_q <= i_q; best_start_q <= AW'(brd_q.start);
          end
          i_q <= i_q + 1'b1;
          state_q <= S_D_SCAN;
        end
        S_D_PUT: begin
          // wait here while the best entry is read
          if (k_q == '0) begin
            k_q <= AW'(1);
          end else begin
            prev_q      <= best_start_q;
            have_prev_q <= 1'b1;
            next_q  <= next_q + AW'(brd_q.size);
            i_q <= '0; found_q <= 1'b0; k_q <= '0;
            state_q <= S_D_SCAN;
          end
        end
        S_D_FILL: begin
          k_q <= k_q + 1'b1;
          if (k_q == AW'(MemUnits - 1)) state_q <= S_DONE;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        // free every unit after reset
        S_CLR: begin
          k_q <= k_q + 1'b1;
          if (k_q == AW'(MemUnits - 1)) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign new_handle_o = done_q ? hdl_q : 8'd0;
  assign idle_o       = (state_q == S_IDLE);

  a_hdl_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && hdl_q != 8'd0 |-> status_q == ffa_pkg::StOk)
    else $error("handle with error status");
  a_issued_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q <= BC'(MaxBlocks)) else $error("handle count overflow");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held");

endmodule

// File: rtl/first_fit_allocator_with_compaction.sv
// First-fit unit allocator with compaction.
// Command channel: start with mode_i, alloc_size_i, erase_handle_i; an item is
// taken at a clock edge with start high and busy low. busy stays high until
// the result strobe. One result per command: done_o is high for one cycle with
// status_o and new_handle_o; the receiver cannot stall it.
// Configuration: cfg_valid_i/cfg_ready_o transfer units_in_use; ready only
// while no command is in flight.
// One sequencer runs every command over the unit map and block table memories:
// alloc examines candidate units one by one and then marks the block's units;
// erase frees the block's units; defragment scans the block table once per
// live block placed and once more, then refills the unit map.
// One command at a time; the next one can be taken in the strobe cycle.
// Reset: no handles issued, units_in_use 128; a clearing pass then frees every
// unit, with busy high and cfg_ready_o low meanwhile.
module first_fit_allocator_with_compaction #(
  parameter int unsigned MemUnits  = ffa_pkg::MemUnitsDef,
  parameter int unsigned MaxBlocks = ffa_pkg::MaxBlocksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode_i,
  input  logic [7:0] alloc_size_i,
  input  logic [7:0] erase_handle_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [7:0] new_handle_o
);

  logic [7:0] units_q;
  logic       idle;

  // hold configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q <= ffa_pkg::UnitsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      units_q <= cfg_data_i;
    end
  end

  assign busy        = !idle;
  assign cfg_ready_o = idle;

  ffa_core #(.MemUnits(MemUnits), .MaxBlocks(MaxBlocks)) u_core (
    .clk_i, .rst_ni,
    .go_i(start && idle),
    .mode_i, .alloc_size_i, .erase_handle_i,
    .units_i(units_q),
    .done_o, .status_o, .new_handle_o,
    .idle_o(idle)
  );

endmodule

// File: tb/first_fit_allocator_with_compaction_test.sv
module first_fit_allocator_with_compaction_test;

  localparam int unsigned Units  = ffa_pkg::MemUnitsDef;
  localparam int unsigned Blocks = ffa_pkg::MaxBlocksDef;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] size;
    logic [7:0] handle;
  } command_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] handle;
  } answer_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] mode_i = ffa_pkg::ModeAlloc;
  logic [7:0] alloc_size_i = '0;
  logic [7:0] erase_handle_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;
  logic       done_o;
  logic [1:0] status_o;
  logic [7:0] new_handle_o;

  command_t command_q[$];
  answer_t  answer_q[$];
  int       fails = 0;
  bit       no_idle = 1'b0;
  int       allocs_queued = 0;

  // Shadow allocator state
  bit         unit_busy[Units];
  logic [8:0] blk_start[Blocks];
  logic [8:0] blk_size[Blocks];
  bit         blk_live[Blocks];
  int         issued = 0;
  logic [7:0] units_cfg = ffa_pkg::UnitsReset;

  first_fit_allocator_with_compaction i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .mode_i(mode_i), .alloc_size_i(alloc_size_i), .erase_handle_i(erase_handle_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .done_o(done_o), .status_o(status_o), .new_handle_o(new_handle_o)
  );

  always #6 clk_i = ~clk_i;

  // Compute the answer to one command and advance the shadow state
  task automatic run_allocator(input command_t c, output answer_t a);
    int lim, s, b, best, next;
    bit fits;
    bit placed[Blocks];
    a.status = ffa_pkg::StOk;
    a.handle = '0;
    lim = (units_cfg > Units) ? Units : units_cfg;
    s = c.size;
    if (c.mode == ffa_pkg::ModeAlloc) begin
      if (issued >= Blocks) begin
        a.status = ffa_pkg::StFull;
      end else if (s == 0 || s > lim) begin
        a.status = ffa_pkg::StNoRoom;
      end else begin
        a.status = ffa_pkg::StNoRoom;
        for (int base = 0; base + s <= lim; base++) begin
          fits = 1'b1;
          for (int k = 0; k < s; k++) if (unit_busy[base + k]) fits = 1'b0;
          if (fits) begin
            for (int k = 0; k < s; k++) unit_busy[base + k] = 1'b1;
            blk_start[issued] = 9'(base);
            blk_size[issued] = 9'(s);
            blk_live[issued] = 1'b1;
            issued++;
            a.status = ffa_pkg::StOk;
            a.handle = 8'(issued);
            break;
          end
        end
      end
    end else if (c.mode == ffa_pkg::ModeErase) begin
      b = c.handle;
      if (b == 0 || b > issued || !blk_live[b - 1]) begin
        a.status = ffa_pkg::StIllegal;
      end else begin
        for (int k = 0; k < blk_size[b - 1]; k++)
          if (blk_start[b - 1] + k < Units) unit_busy[blk_start[b - 1] + k] = 1'b0;
        blk_live[b - 1] = 1'b0;
      end
    end else if (c.mode == ffa_pkg::ModeDefrag) begin
      next = 0;
      for (int i = 0; i < Blocks; i++) placed[i] = 1'b0;
      forever begin
        best = -1;
        for (int i = 0; i < issued; i++)
          if (blk_live[i] && !placed[i] && (best < 0 || blk_start[i] < blk_start[best]))
            best = i;
        if (best < 0) break;
        placed[best] = 1'b1;
        blk_start[best] = 9'(next);
        next += blk_size[best];
      end
      for (int i = 0; i < Units; i++) unit_busy[i] = (i < next);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fails++;
  endtask

  // Driver: predict on each transfer, then present the next command or idle
  always @(posedge clk_i) begin
    command_t c;
    answer_t a;
    if (rst_ni) begin
      if (start && !busy) begin
        c.mode = mode_i;
        c.size = alloc_size_i;
        c.handle = erase_handle_i;
        run_allocator(c, a);
        answer_q.insert(answer_q.size(), a);
      end
      if (!start || !busy) begin
        if (command_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 24)) begin
          c = command_q.pop_front();
          start <= 1'b1;
          mode_i <= c.mode;
          alloc_size_i <= c.size;
          erase_handle_i <= c.handle;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each strobed answer against the oldest prediction
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected answer, status", status_o, -1);
      end else begin
        a = answer_q.pop_front();
        if (status_o !== a.status) report_mismatch("status", status_o, a.status);
        if (new_handle_o !== a.handle) report_mismatch("new_handle", new_handle_o, a.handle);
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] m, input logic [7:0] s, input logic [7:0] h);
    command_t c;
    c.mode = m;
    c.size = s;
    c.handle = h;
    command_q.insert(command_q.size(), c);
    if (m == ffa_pkg::ModeAlloc) allocs_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (command_q.size() != 0 || start || answer_q.size() != 0);
  endtask

  // Transfer one units_in_use value while the block is idle
  task automatic write_units(input logic [7:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    units_cfg = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    int r;
    logic [7:0] s, h;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 199);
      s = 8'((r % 7 == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6));
      h = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(1, allocs_queued + 1));
      if (r < 104) begin
        queue_cmd(ffa_pkg::ModeAlloc, s, 8'($urandom_range(0, 255)));
      end else if (r < 184) begin
        queue_cmd(ffa_pkg::ModeErase, 8'($urandom_range(0, 255)), h);
      end else if (r < 186) begin
        queue_cmd(ffa_pkg::ModeDefrag, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else begin
        queue_cmd(ffa_pkg::ModeUnused, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_units(8'd128);
    // Directed: size extremes, bad handles, unused mode, compaction
    queue_cmd(ffa_pkg::ModeAlloc, 8'd0, 8'd255);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd128, 8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd1, 8'd0);
    queue_cmd(ffa_pkg::ModeUnused, 8'd255, 8'd255);
    queue_cmd(ffa_pkg::ModeErase, 8'd0, 8'd0);
    queue_cmd(ffa_pkg::ModeErase, 8'd0, 8'd1);
    queue_cmd(ffa_pkg::ModeErase, 8'd255, 8'd1);
    queue_cmd(ffa_pkg::ModeErase, 8'd0, 8'd255);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd255, 8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd5, 8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd3, 8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd4, 8'd0);
    queue_cmd(ffa_pkg::ModeErase, 8'd0, 8'd3);
    queue_cmd(ffa_pkg::ModeDefrag, 8'd0, 8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd2, 8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd130, 8'd0);
    write_units(8'd1);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd1, 8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd1, 8'd0);
    queue_cmd(ffa_pkg::ModeErase, 8'd0, 8'd6);
    queue_cmd(ffa_pkg::ModeDefrag, 8'd0, 8'd0);
    write_units(8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd1, 8'd0);
    write_units(8'd255);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd120, 8'd0);
    queue_cmd(ffa_pkg::ModeAlloc, 8'd128, 8'd0);
    // Random phases under several register settings
    write_units(8'd40);
    queue_random(320);
    write_units(8'($urandom_range(1, 128)));
    no_idle = 1'b1;
    queue_random(320);
    wait_drained();
    no_idle = 1'b0;
    write_units(8'd128);
    queue_random(320);
    write_units(8'd255);
    queue_random(320);
    write_units(8'd1);
    queue_random(300);
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (fails == 0) $display("first_fit_allocator_with_compaction test passed");
    else $display("first_fit_allocator_with_compaction test failed");
    $finish;
  end

  initial begin
    #(12 * 6000000);
    $display("first_fit_allocator_with_compaction test failed");
    $finish;
  end

endmodule
